@@ hw/rtl/depq_pkg.sv @@
// Shared constants and types for the double-ended priority queue.
package depq_pkg;

	localparam int CAPACITY = 256;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = AW + 1;
	localparam int KW       = 24;
	localparam int IW       = 24;
	localparam int EW       = KW + IW;

	localparam logic [1:0] FUNC_INSERT  = 2'd0;
	localparam logic [1:0] FUNC_POP_MAX = 2'd1;
	localparam logic [1:0] FUNC_POP_MIN = 2'd2;
	localparam logic [1:0] FUNC_RSVD    = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// entry word: priority above id
	typedef struct packed {
		logic [KW-1:0] prio;
		logic [IW-1:0] id;
	} entry_t;

endpackage

@@ hw/rtl/depq_ram.sv @@
// Simple dual-port RAM, one write and one registered read per cycle.
module depq_ram #(
	parameter int AW = 8,
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/double_ended_priority_queue.sv @@
// Top level: double-ended priority queue over a circular sorted RAM.
//
//  channel | dir | fields
//  s_axis  | in  | tdata {priority_req, client_id}, tuser func
//  m_axis  | out | tdata popped_id, tuser status
//
// Entries sit in one RAM sorted ascending, as a ring starting at base_q.
// Pop-min reads the entry at base and advances base; pop-max reads the top entry.
// Failed requests are answered from IDLE without a pop or shift state.
// Insert into an empty queue writes at base; otherwise it walks down from the top,
// moving each entry of equal or higher priority up one slot, one RAM write per cycle.
// Reset clears fill count, base and control; RAM contents need no clearing.
// A new request is taken only in IDLE with the result slot free or draining.
module double_ended_priority_queue
	import depq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [23:0] client_id, [47:24] priority_req
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [23:0] popped_id
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_POP   = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_FINAL = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] cur_q;       // logical index under read in insert walk
	logic          pop_min_q;
	entry_t        new_q;
	logic          ovalid_q;
	logic [IW-1:0] oid_q;
	logic [1:0]    ost_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;
	logic          acc;
	logic [1:0]    func;
	entry_t        in_e;
	logic [AW-1:0] top_idx;
	logic          res_set;     // a result is loaded at this edge

	depq_ram #(.AW(AW), .DW(EW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign s_tready = (state_q == S_IDLE) && (!ovalid_q || m_tready);
	assign acc      = s_tvalid && s_tready;
	assign func     = s_tuser;
	assign in_e.id   = s_tdata[IW-1:0];
	assign in_e.prio = s_tdata[EW-1:IW];
	assign top_idx  = AW'(fill_q - CW'(1));

	// pop data, full insert or empty pop
	assign res_set = (state_q == S_POP) ||
		(acc && (((func == FUNC_INSERT) && (fill_q == CW'(CAPACITY))) ||
		(((func == FUNC_POP_MAX) || (func == FUNC_POP_MIN)) && (fill_q == '0))));

	assign m_tvalid = ovalid_q;
	assign m_tdata  = oid_q;
	assign m_tuser  = ost_q;

	// RAM port steering; addresses are logical index plus base, wrapping
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = new_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (func)
						FUNC_INSERT: begin
							if (fill_q == '0) begin
								we    = 1'b1;
								waddr = base_q;
								wdata = in_e;
							end else if (fill_q != CW'(CAPACITY)) begin
								re    = 1'b1;
								raddr = base_q + top_idx;
							end
						end
						FUNC_POP_MAX: begin
							re    = 1'b1;
							raddr = base_q + top_idx;
						end
						FUNC_POP_MIN: begin
							re    = 1'b1;
							raddr = base_q;
						end
						default: ;
					endcase
				end
			end
			S_SHIFT: begin
				we = 1'b1;
				waddr = base_q + cur_q + AW'(1);
				if (rdata.prio >= new_q.prio) begin
					wdata = rdata;
					if (cur_q != '0) begin
						re    = 1'b1;
						raddr = base_q + cur_q - AW'(1);
					end
				end else begin
					wdata = new_q;
				end
			end
			S_FINAL: begin
				we    = 1'b1;
				waddr = base_q;
				wdata = new_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			base_q    <= '0;
			cur_q     <= '0;
			pop_min_q <= 1'b0;
			ovalid_q  <= 1'b0;
			ost_q     <= ST_OK;
			oid_q     <= '0;
		end else begin
			if (res_set) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && m_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						new_q     <= in_e;
						pop_min_q <= (func == FUNC_POP_MIN);
						case (func)
							FUNC_INSERT: begin
								if (fill_q == CW'(CAPACITY)) begin
									oid_q    <= '0;
									ost_q    <= ST_FULL;
								end else if (fill_q == '0) begin
									fill_q <= CW'(1);
								end else begin
									cur_q   <= top_idx;
									state_q <= S_SHIFT;
								end
							end
							FUNC_POP_MAX, FUNC_POP_MIN: begin
								if (fill_q == '0) begin
									oid_q    <= '0;
									ost_q    <= ST_EMPTY;
								end else begin
									state_q <= S_POP;
								end
							end
							default: ;
						endcase
					end
				end
				S_POP: begin
					oid_q    <= rdata.id;
					ost_q    <= ST_OK;
					fill_q   <= fill_q - CW'(1);
					if (pop_min_q) begin
						base_q <= base_q + AW'(1);
					end
					state_q <= S_IDLE;
				end
				S_SHIFT: begin
					if (rdata.prio >= new_q.prio) begin
						if (cur_q == '0) begin
							state_q <= S_FINAL;
						end else begin
							cur_q <= cur_q - AW'(1);
						end
					end else begin
						fill_q  <= fill_q + CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_FINAL: begin
					fill_q  <= fill_q + CW'(1);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/depq_checker.sv @@
// Port-level checks for the priority queue, bound to the top level.
module depq_checker
	import depq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL))
		else $error("bad status code");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
		else $error("failed request carries nonzero id");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("request taken while result slot blocked");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ sim/depq_checker.sv @@
// Checker for the double-ended priority queue: watches both channels, predicts, compares.
module depq_scoreboard
	import depq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fail_count,
	output int          pending,
	output int          held
);

	typedef struct packed {
		logic [23:0] id;
		logic [1:0]  status;
	} answer_t;

	// sorted ascending; among equal priorities the newest sits lowest
	entry_t  sorted_q[$];
	answer_t answer_q[$];

	assign pending = answer_q.size();
	assign held    = sorted_q.size();

	initial fail_count = 0;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic model_request(input logic [1:0] func, input logic [23:0] id,
			input logic [23:0] prio);
		int pos;
		entry_t e;
		answer_t a;
		if (func == FUNC_INSERT) begin
			if (sorted_q.size() >= CAPACITY) begin
				a.id = '0; a.status = ST_FULL; answer_q.push_back(a);
			end else begin
				pos = 0;
				while (pos < sorted_q.size() && sorted_q[pos].prio < prio) pos++;
				e.prio = prio; e.id = id;
				sorted_q.insert(pos, e);
			end
		end else if (func == FUNC_POP_MAX || func == FUNC_POP_MIN) begin
			if (sorted_q.size() == 0) begin
				a.id = '0; a.status = ST_EMPTY;
			end else if (func == FUNC_POP_MAX) begin
				e = sorted_q.pop_back(); a.id = e.id; a.status = ST_OK;
			end else begin
				e = sorted_q.pop_front(); a.id = e.id; a.status = ST_OK;
			end
			answer_q.push_back(a);
		end
	endtask

	always @(posedge clk) begin
		answer_t a;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0)
					report($sformatf("unexpected result id=%0h st=%0d", m_tdata, m_tuser));
				else begin
					a = answer_q.pop_front();
					if (m_tdata !== a.id)
						report($sformatf("id %0h, want %0h", m_tdata, a.id));
					if (m_tuser !== a.status)
						report($sformatf("status %0d, want %0d", m_tuser, a.status));
				end
			end
			if (s_tvalid && s_tready)
				model_request(s_tuser, s_tdata[23:0], s_tdata[47:24]);
		end
	end

endmodule

@@ sim/tb_double_ended_priority_queue.sv @@
// Testbench top: stimulus, idling phases and verdict for the priority queue.
module tb_double_ended_priority_queue
	import depq_pkg::*;
;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	int          fail_count;
	int          pending;
	int          held;
	int          send_idle;
	int          recv_stall;
	longint      cycles = 0;

	localparam longint CYCLE_LIMIT = 2000000;

	double_ended_priority_queue DUT (.*);

	depq_scoreboard checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// receiver stalls at random per phase setting
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one request, held until taken; random idle gap before it
	task automatic send(input logic [1:0] func, input logic [23:0] id, input logic [23:0] prio);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {prio, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic random_phase(input int n, input int idle, input int stall);
		int r;
		logic [1:0] f;
		send_idle = idle; recv_stall = stall;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			// bias toward inserts when low, pops when high, so both ends get hit
			if (r < 2) f = FUNC_RSVD;
			else if (r < (held > 200 ? 30 : 55)) f = FUNC_INSERT;
			else f = (r & 1) ? FUNC_POP_MAX : FUNC_POP_MIN;
			if ($urandom_range(3) == 0)
				send(f, 24'($urandom), 24'($urandom_range(7)));   // many ties
			else
				send(f, 24'($urandom), 24'($urandom));
		end
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	initial begin
		send_idle = 0; recv_stall = 0;
		arst_n = 0; s_tvalid = 0; s_tdata = '0; s_tuser = FUNC_INSERT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pops, extremes, ties, unused code
		send(FUNC_POP_MAX, 24'h0, 24'h0);
		send(FUNC_POP_MIN, 24'h0, 24'h0);
		send(FUNC_INSERT, 24'hFFFFFF, 24'hFFFFFF);
		send(FUNC_INSERT, 24'h000000, 24'h000000);
		send(FUNC_INSERT, 24'h000011, 24'h000005);
		send(FUNC_INSERT, 24'h000022, 24'h000005);
		send(FUNC_INSERT, 24'h000033, 24'h000005);
		send(FUNC_RSVD, 24'hABCDEF, 24'h123456);
		send(FUNC_POP_MAX, 24'h0, 24'h0);
		send(FUNC_POP_MAX, 24'h0, 24'h0);
		send(FUNC_POP_MIN, 24'h0, 24'h0);
		send(FUNC_POP_MIN, 24'h0, 24'h0);
		send(FUNC_POP_MIN, 24'h0, 24'h0);
		send(FUNC_POP_MIN, 24'h0, 24'h0);
		drain();

		// fill to capacity, one rejected insert, then empty it again
		for (int k = 0; k < CAPACITY; k++)
			send(FUNC_INSERT, 24'($urandom), 24'($urandom_range(15)));
		send(FUNC_INSERT, 24'h5A5A5A, 24'h0);
		for (int k = 0; k < CAPACITY; k++)
			send(k[0] ? FUNC_POP_MAX : FUNC_POP_MIN, 24'h0, 24'h0);
		drain();

		random_phase(125, 0, 0);
		random_phase(125, 58, 0);
		drain();
		random_phase(125, 0, 58);
		random_phase(125, 9, 9);
		drain();

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
